// File: hw/rtl/slnt_pkg.sv
// Shared sizes, result codes and controller/datapath interface types for
// the sorted line number table. No dependencies.
package slnt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam int KEY_W  = 16;
  localparam int OFF_W  = 16;
  localparam int STAT_W = 3;
  localparam int POS_W  = 8;
  localparam int ECNT_W = 9;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FIND   = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } result_t;

  // What the datapath loads into the result registers.
  typedef enum logic [1:0] {
    OUT_ZERO,
    OUT_HIT_READ,
    OUT_HIT_NEW,
    OUT_SLOT_NEW
  } out_mode_t;

  typedef struct packed {
    logic      load;
    logic      scan;
    logic      update_wr;
    logic      shift;
    logic      fill;
    logic      out_load;
    out_mode_t out_mode;
  } dp_cmd_t;

  typedef struct packed {
    logic is_find;
    logic hit;
    logic miss;
    logic full;
    logic shift_done;
  } dp_stat_t;

endpackage

// File: hw/rtl/slnt_dp.sv
// Datapath of the sorted line number table: key/offset memories, scan and
// shift counters, entry count and result registers. Uses slnt_pkg.
module slnt_dp import slnt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  output dp_stat_t         stat,
  input  logic             op,
  input  logic [KEY_W-1:0] line_number,
  input  logic [OFF_W-1:0] code_offset,
  output logic [IDX_W-1:0] out_pos,
  output logic [OFF_W-1:0] out_off,
  output logic [CNT_W-1:0] count
);

  logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
  logic [OFF_W-1:0] off_mem [TABLE_DEPTH];

  logic             req_op;
  logic [KEY_W-1:0] req_key;
  logic [OFF_W-1:0] req_off;

  logic [KEY_W-1:0] rd_key;
  logic [OFF_W-1:0] rd_off;

  logic [CNT_W-1:0] scan_idx;
  logic             scan_pend;
  logic [IDX_W-1:0] pend_idx;

  logic [CNT_W-1:0] slot;
  logic [CNT_W-1:0] sh_idx;
  logic             sh_pend;
  logic [IDX_W-1:0] sh_dest;

  logic             scan_issue;
  logic             sh_issue;
  logic [CNT_W-1:0] sh_prev;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             hit;
  logic             miss;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [KEY_W-1:0] wkey;
  logic [OFF_W-1:0] woff;

  always_comb begin
    scan_issue = cmd.scan && (scan_idx < count);
    sh_issue   = cmd.shift && (sh_idx > slot);
    sh_prev    = sh_idx - CNT_W'(1);
    rd_en      = scan_issue || sh_issue;
    rd_addr    = scan_issue ? scan_idx[IDX_W-1:0] : sh_prev[IDX_W-1:0];

    // Table is sorted with unique keys: stop at the first key not below.
    hit  = scan_pend && (rd_key == req_key);
    miss = (scan_pend && (rd_key > req_key)) || (!scan_pend && (scan_idx >= count));

    stat.is_find    = (req_op == OP_FIND);
    stat.hit        = hit;
    stat.miss       = miss;
    stat.full       = (count == CNT_W'(TABLE_DEPTH));
    stat.shift_done = !sh_pend && !(sh_idx > slot);

    // One write port, shared by shift moves, updates and the final fill.
    we    = 1'b0;
    waddr = slot[IDX_W-1:0];
    wkey  = req_key;
    woff  = req_off;
    if (sh_pend) begin
      we    = 1'b1;
      waddr = sh_dest;
      wkey  = rd_key;
      woff  = rd_off;
    end else if (cmd.update_wr) begin
      we    = 1'b1;
      waddr = pend_idx;
    end else if (cmd.fill) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key <= key_mem[rd_addr];
      rd_off <= off_mem[rd_addr];
    end
    if (we) begin
      key_mem[waddr] <= wkey;
      off_mem[waddr] <= woff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend <= 1'b0;
      sh_pend   <= 1'b0;
      count     <= '0;
    end else begin
      scan_pend <= scan_issue;
      sh_pend   <= sh_issue;
      if (cmd.fill) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op   <= op;
      req_key  <= line_number;
      req_off  <= code_offset;
      scan_idx <= '0;
    end
    if (scan_issue) begin
      scan_idx <= scan_idx + CNT_W'(1);
      pend_idx <= scan_idx[IDX_W-1:0];
    end
    // Latch the insertion point and arm the shift from the top entry down.
    if (cmd.scan && miss) begin
      slot   <= scan_pend ? {1'b0, pend_idx} : count;
      sh_idx <= count;
    end
    if (sh_issue) begin
      sh_idx  <= sh_prev;
      sh_dest <= sh_idx[IDX_W-1:0];
    end
    if (cmd.out_load) begin
      case (cmd.out_mode)
        OUT_HIT_READ: begin
          out_pos <= pend_idx;
          out_off <= rd_off;
        end
        OUT_HIT_NEW: begin
          out_pos <= pend_idx;
          out_off <= req_off;
        end
        OUT_SLOT_NEW: begin
          out_pos <= slot[IDX_W-1:0];
          out_off <= req_off;
        end
        default: begin
          out_pos <= '0;
          out_off <= '0;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_fill_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fill |-> (count < CNT_W'(TABLE_DEPTH)))
    else $error("fill into a full table");

  a_shift_above_slot: assert property (@(posedge clk) disable iff (rst)
    sh_pend |-> ({1'b0, sh_dest} > slot))
    else $error("shift move writes at or below the insertion point");

endmodule

// File: hw/rtl/slnt_ctrl.sv
// Controller of the sorted line number table: sequences scan, update,
// shift and fill, and raises the result strobe. Uses slnt_pkg.
module slnt_ctrl import slnt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  dp_stat_t stat,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done,
  output result_t status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } state_t;

  state_t  state;
  state_t  state_next;
  logic    done_next;
  result_t status_next;

  always_comb begin
    cmd         = '0;
    cmd.out_mode = OUT_ZERO;
    state_next  = state;
    done_next   = 1'b0;
    status_next = status;
    case (state)
      S_IDLE: begin
        cmd.load = start;
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit) begin
          cmd.out_load = 1'b1;
          done_next    = 1'b1;
          state_next   = S_IDLE;
          if (stat.is_find) begin
            cmd.out_mode = OUT_HIT_READ;
            status_next  = ST_FOUND;
          end else begin
            cmd.update_wr = 1'b1;
            cmd.out_mode  = OUT_HIT_NEW;
            status_next   = ST_UPDATED;
          end
        end else if (stat.miss) begin
          if (stat.is_find || stat.full) begin
            cmd.out_load = 1'b1;
            done_next    = 1'b1;
            state_next   = S_IDLE;
            status_next  = stat.is_find ? ST_NOT_FOUND : ST_FULL;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          cmd.fill     = 1'b1;
          cmd.out_load = 1'b1;
          cmd.out_mode = OUT_SLOT_NEW;
          done_next    = 1'b1;
          status_next  = ST_INSERTED;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      status <= ST_INSERTED;
    end else begin
      state  <= state_next;
      done   <= done_next;
      status <= status_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// File: hw/rtl/sorted_line_number_table.sv
// Sorted line number table: ascending line numbers with code offsets.
// Find and update use a linear scan; an insert scans too, then shifts the
// larger entries up one entry per cycle through the single-write memory.
// Throughput: one item at a time; busy drops with the strobe.
// Synchronous reset empties the table; results cannot be stalled.
module sorted_line_number_table import slnt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [KEY_W-1:0]  line_number,
  input  logic [OFF_W-1:0]  code_offset,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  position,
  output logic [OFF_W-1:0]  found_offset,
  output logic [ECNT_W-1:0] entry_count
);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  result_t          res_status;
  logic [IDX_W-1:0] out_pos;
  logic [CNT_W-1:0] count;

  slnt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done),
    .status (res_status)
  );

  slnt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .op          (op),
    .line_number (line_number),
    .code_offset (code_offset),
    .out_pos     (out_pos),
    .out_off     (found_offset),
    .count       (count)
  );

  assign status      = res_status;
  assign position    = POS_W'(out_pos);
  assign entry_count = ECNT_W'(count);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for sorted_line_number_table: issues insert and find
// transfers, predicts each result with a local sorted table and checks it.
// Depends on slnt_pkg and the sorted_line_number_table RTL.
module tb_top;
  import slnt_pkg::*;

  typedef struct {
    result_t           status;
    logic [POS_W-1:0]  position;
    logic [OFF_W-1:0]  found_offset;
    logic [ECNT_W-1:0] entry_count;
  } line_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              op;
  logic [KEY_W-1:0]  line_number;
  logic [OFF_W-1:0]  code_offset;
  logic              done;
  logic [STAT_W-1:0] status;
  logic [POS_W-1:0]  position;
  logic [OFF_W-1:0]  found_offset;
  logic [ECNT_W-1:0] entry_count;

  // Local copy of the sorted table
  logic [KEY_W-1:0] line_keys [TABLE_DEPTH];
  logic [OFF_W-1:0] line_offsets [TABLE_DEPTH];
  int               line_count = 0;

  line_result_t expected_line_results [$];
  int           fail_count = 0;
  bit           no_idle = 1'b0;

  sorted_line_number_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .line_number  (line_number),
    .code_offset  (code_offset),
    .done         (done),
    .status       (status),
    .position     (position),
    .found_offset (found_offset),
    .entry_count  (entry_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic predict_table_op(input logic op_i, input logic [KEY_W-1:0] key,
                                  input logic [OFF_W-1:0] offs,
                                  output line_result_t res);
    int i;
    int slot;
    bit hit;
    hit = 1'b0;
    slot = 0;
    for (i = 0; i < line_count; i++) begin
      if (!hit && line_keys[i] == key) begin
        hit = 1'b1;
        slot = i;
      end
    end
    res.status       = ST_NOT_FOUND;
    res.position     = '0;
    res.found_offset = '0;
    if (op_i == OP_FIND) begin
      if (hit) begin
        res.status       = ST_FOUND;
        res.position     = POS_W'(slot);
        res.found_offset = line_offsets[slot];
      end
    end else if (hit) begin
      line_offsets[slot] = offs;
      res.status         = ST_UPDATED;
      res.position       = POS_W'(slot);
      res.found_offset   = offs;
    end else if (line_count >= TABLE_DEPTH) begin
      res.status = ST_FULL;
    end else begin
      // Shift larger keys up one slot, then fill the gap
      slot = line_count;
      while (slot > 0 && line_keys[slot-1] > key) begin
        line_keys[slot]    = line_keys[slot-1];
        line_offsets[slot] = line_offsets[slot-1];
        slot--;
      end
      line_keys[slot]    = key;
      line_offsets[slot] = offs;
      line_count++;
      res.status       = ST_INSERTED;
      res.position     = POS_W'(slot);
      res.found_offset = offs;
    end
    res.entry_count = ECNT_W'(line_count);
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(16, 80);
  endfunction

  // Start stays high across back-to-back transfers; drop it only for a gap
  task automatic issue_table_op(input logic op_i, input logic [KEY_W-1:0] key,
                                input logic [OFF_W-1:0] offs);
    int           gap;
    line_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    op          <= op_i;
    line_number <= key;
    code_offset <= offs;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_table_op(op_i, key, offs, res);
    expected_line_results.push_back(res);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (expected_line_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_extremes();
    issue_table_op(OP_FIND,   16'h0000, 16'h0000);
    issue_table_op(OP_FIND,   16'hFFFF, 16'hFFFF);
    issue_table_op(OP_INSERT, 16'h8000, 16'hFFFF);
    issue_table_op(OP_INSERT, 16'hFFFF, 16'h0000);
    issue_table_op(OP_INSERT, 16'h0000, 16'hAAAA);
    issue_table_op(OP_INSERT, 16'h7FFF, 16'h5555);
    issue_table_op(OP_INSERT, 16'h0001, 16'h0001);
    issue_table_op(OP_INSERT, 16'hFFFE, 16'h8000);
    issue_table_op(OP_INSERT, 16'h8000, 16'h1234);
    issue_table_op(OP_INSERT, 16'h0000, 16'hFFFF);
    issue_table_op(OP_INSERT, 16'hFFFF, 16'h7FFF);
    issue_table_op(OP_FIND,   16'h0000, 16'hFFFF);
    issue_table_op(OP_FIND,   16'h0001, 16'h0000);
    issue_table_op(OP_FIND,   16'h7FFF, 16'h1111);
    issue_table_op(OP_FIND,   16'h8000, 16'h0000);
    issue_table_op(OP_FIND,   16'hFFFE, 16'h0000);
    issue_table_op(OP_FIND,   16'hFFFF, 16'h0000);
    issue_table_op(OP_FIND,   16'h8001, 16'hFFFF);
    issue_table_op(OP_FIND,   16'h5555, 16'h0000);
  endtask

  // Keys mostly from a small pool: lots of updates and hits, table stays small
  task automatic test_random_small_table();
    logic [KEY_W-1:0] key_pool [48];
    logic [KEY_W-1:0] key;
    int               n;
    foreach (key_pool[k]) key_pool[k] = KEY_W'($urandom);
    for (n = 0; n < 600; n++) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (n % 150 == 149) drain_results();
      if ($urandom_range(0, 9) == 0) key = KEY_W'($urandom);
      else key = key_pool[$urandom_range(0, 47)];
      issue_table_op(($urandom_range(0, 1) == 1) ? OP_FIND : OP_INSERT, key,
                     OFF_W'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_fill_to_capacity();
    int n;
    n = 0;
    while (line_count < TABLE_DEPTH) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      issue_table_op(OP_INSERT, KEY_W'($urandom), OFF_W'($urandom));
      n++;
    end
    no_idle = 1'b0;
  endtask

  task automatic test_full_table();
    logic [KEY_W-1:0] key;
    int               n;
    int               i;
    int               r;
    bit               hit;
    // Pick a key that is not in the table
    do begin
      key = KEY_W'($urandom);
      hit = 1'b0;
      for (i = 0; i < line_count; i++) if (line_keys[i] == key) hit = 1'b1;
    end while (hit);
    issue_table_op(OP_FIND,   key, 16'h0000);
    issue_table_op(OP_INSERT, key, 16'hFFFF);
    issue_table_op(OP_FIND,   line_keys[TABLE_DEPTH-1], 16'h0000);
    issue_table_op(OP_INSERT, line_keys[TABLE_DEPTH-1], 16'hFFFF);
    issue_table_op(OP_INSERT, line_keys[0], 16'h0000);
    issue_table_op(OP_FIND,   line_keys[0], 16'hFFFF);
    for (n = 0; n < 480; n++) begin
      if (n % 32 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      if (r < 4)
        issue_table_op(OP_FIND, line_keys[$urandom_range(0, line_count-1)],
                       OFF_W'($urandom));
      else if (r == 4)
        issue_table_op(OP_FIND, KEY_W'($urandom), OFF_W'($urandom));
      else if (r < 8)
        issue_table_op(OP_INSERT, line_keys[$urandom_range(0, line_count-1)],
                       OFF_W'($urandom));
      else
        issue_table_op(OP_INSERT, KEY_W'($urandom), OFF_W'($urandom));
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    line_result_t exp_res;
    if (!rst && done) begin
      if (expected_line_results.size() == 0) begin
        $error("unexpected result: status %0d position %0d", status, position);
        fail_count++;
      end else begin
        exp_res = expected_line_results.pop_front();
        if (status !== exp_res.status) begin
          $error("status: expected %0d, actual %0d", exp_res.status, status);
          fail_count++;
        end
        if (position !== exp_res.position) begin
          $error("position: expected %0d, actual %0d", exp_res.position, position);
          fail_count++;
        end
        if (found_offset !== exp_res.found_offset) begin
          $error("found_offset: expected %h, actual %h", exp_res.found_offset,
                 found_offset);
          fail_count++;
        end
        if (entry_count !== exp_res.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", exp_res.entry_count,
                 entry_count);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    op          <= OP_INSERT;
    line_number <= '0;
    code_offset <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed_extremes();
    drain_results();
    test_random_small_table();
    drain_results();
    test_fill_to_capacity();
    drain_results();
    test_full_table();
    drain_results();
    repeat (2 * TABLE_DEPTH + 8) @(posedge clk);
    if (expected_line_results.size() != 0) begin
      $error("%0d results never arrived", expected_line_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("sorted_line_number_table test passed");
    end else begin
      $display("sorted_line_number_table test failed");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("sorted_line_number_table test failed");
    $finish;
  end

endmodule
